// ===== rtl/dws_pkg.sv =====
// Shared types, constants and saturating arithmetic helpers for the
// dispersive wave stencil. No dependencies.
`default_nettype none

package dws_pkg;

    localparam int DataWidth  = 32;
    localparam int FracBits   = 16;
    localparam int MaxCells   = 32;
    localparam int QueueDepth = 2;

    typedef logic signed [DataWidth-1:0] word_t;

    localparam word_t WordMax = word_t'({1'b0, {(DataWidth-1){1'b1}}});
    localparam word_t WordMin = word_t'({1'b1, {(DataWidth-1){1'b0}}});

    typedef logic [3:0] cfg_idx_t;
    localparam cfg_idx_t CfgCellsX     = 4'd0;
    localparam cfg_idx_t CfgCellsY     = 4'd1;
    localparam cfg_idx_t CfgSideNeu    = 4'd2;
    localparam cfg_idx_t CfgNeighbor   = 4'd3;
    localparam cfg_idx_t CfgIntDir     = 4'd4;
    localparam cfg_idx_t CfgAlpha      = 4'd5;
    localparam cfg_idx_t CfgInvDx      = 4'd6;
    localparam cfg_idx_t CfgInvDy      = 4'd7;

    localparam logic [1:0] SideWest  = 2'd0;
    localparam logic [1:0] SideEast  = 2'd1;
    localparam logic [1:0] SideSouth = 2'd2;
    localparam logic [1:0] SideNorth = 2'd3;

    typedef struct packed {
        logic [5:0]  cells_x;
        logic [5:0]  cells_y;
        logic [3:0]  phys_side_neumann;
        logic [3:0]  neighbor_present;
        logic        interior_dirichlet;
        logic [30:0] alpha_coef;
        logic [30:0] inv_dx;
        logic [30:0] inv_dy;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] depth;
        logic signed [31:0] comp_x;
        logic signed [31:0] comp_y;
    } in_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic               depth_error;
        logic               last_cell;
    } out_t;

    typedef struct packed {
        word_t             hc;
        word_t             hl;
        word_t             hr;
        word_t             hd;
        word_t             hu;
        word_t [2:0][2:0]  ex;
        word_t [2:0][2:0]  ey;
        logic              err;
        logic              last;
    } job_t;

    typedef enum logic [1:0] {MODE_KEEP, MODE_COPY, MODE_NEG} mode_t;

    function automatic word_t sat_wide(input logic signed [DataWidth:0] s);
        if (s[DataWidth] != s[DataWidth-1]) begin
            return s[DataWidth] ? WordMin : WordMax;
        end
        return s[DataWidth-1:0];
    endfunction

    function automatic word_t add_s(input word_t a, input word_t b);
        return sat_wide({a[DataWidth-1], a} + {b[DataWidth-1], b});
    endfunction

    function automatic word_t sub_s(input word_t a, input word_t b);
        return sat_wide({a[DataWidth-1], a} - {b[DataWidth-1], b});
    endfunction

    function automatic word_t neg_s(input word_t a);
        return sat_wide({(DataWidth+1){1'b0}} - {a[DataWidth-1], a});
    endfunction

    // Exact sum or difference halved with rounding toward minus infinity.
    function automatic word_t half_sum(input word_t a, input word_t b);
        logic signed [DataWidth:0] s;
        s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
        return s[DataWidth:1];
    endfunction

    function automatic word_t half_diff(input word_t a, input word_t b);
        logic signed [DataWidth:0] s;
        s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
        return s[DataWidth:1];
    endfunction

    function automatic word_t quarter(input word_t a);
        return {{2{a[DataWidth-1]}}, a[DataWidth-1:2]};
    endfunction

    function automatic mode_t side_mode(input logic [3:0] neu, input logic [3:0] nbr,
                                        input logic idir, input logic [1:0] side);
        if (!nbr[side]) begin
            return neu[side] ? MODE_COPY : MODE_NEG;
        end
        return idir ? MODE_NEG : MODE_KEEP;
    endfunction

    function automatic word_t apply_mode(input mode_t m, input word_t loaded, input word_t src);
        case (m)
            MODE_COPY: return src;
            MODE_NEG:  return neg_s(src);
            default:   return loaded;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dws_front.sv =====
// Front end of the stencil: accepts raster items, keeps the line stores and
// the 3x3 window, fixes edge ghosts and queues one job per interior cell.
// Depends on dws_pkg.
`default_nettype none

module dws_front #(
    parameter int MAX_CELLS = dws_pkg::MaxCells
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire dws_pkg::cfg_t  cfg,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire dws_pkg::in_t   s_data,
    output logic                push,
    output dws_pkg::job_t       push_job,
    input  wire logic           q_full
);

    localparam int Line = MAX_CELLS + 2;
    localparam int CW   = $clog2(Line);

    typedef enum logic [1:0] {F_IDLE, F_UPD, F_PUSH} state_t;
    typedef dws_pkg::word_t [2:0] trio_t;

    state_t          state_reg;
    logic [CW-1:0]   col_cnt_reg, row_cnt_reg, cur_col_reg, cur_row_reg;
    dws_pkg::in_t    in_reg;
    trio_t           line0_mem [Line];
    trio_t           line1_mem [Line];
    trio_t           line0_rd_reg, line1_rd_reg, in_trio;
    dws_pkg::word_t  win_reg [3][3][3];
    dws_pkg::word_t  fix_w [2][3][3];
    logic [CW-1:0]   cx_eff, cy_eff, cx_p1, cy_p1;
    logic            accept, interior;
    logic [2:0]      row_ok, col_ok;
    logic            at_w, at_e, at_s, at_n;
    dws_pkg::mode_t  m_w, m_e, m_s, m_n;

    assign s_ready = (state_reg == F_IDLE);
    assign accept  = s_valid && s_ready;
    assign in_trio = {in_reg.comp_y, in_reg.comp_x, in_reg.depth};

    always_comb begin
        if (cfg.cells_x == '0) begin
            cx_eff = CW'(1);
        end else if (32'(cfg.cells_x) > 32'(MAX_CELLS)) begin
            cx_eff = CW'(MAX_CELLS);
        end else begin
            cx_eff = CW'(cfg.cells_x);
        end
        if (cfg.cells_y == '0) begin
            cy_eff = CW'(1);
        end else if (32'(cfg.cells_y) > 32'(MAX_CELLS)) begin
            cy_eff = CW'(MAX_CELLS);
        end else begin
            cy_eff = CW'(cfg.cells_y);
        end
    end

    assign cx_p1 = cx_eff + CW'(1);
    assign cy_p1 = cy_eff + CW'(1);

    assign interior = (cur_col_reg >= CW'(2)) && (cur_row_reg >= CW'(2)) &&
                      (cur_col_reg <= cx_p1) && (cur_row_reg <= cy_p1);

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg       <= s_data;
            line0_rd_reg <= line0_mem[col_cnt_reg];
            line1_rd_reg <= line1_mem[col_cnt_reg];
        end
        if (state_reg == F_UPD) begin
            line1_mem[cur_col_reg] <= line0_rd_reg;
            line0_mem[cur_col_reg] <= in_trio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            for (int p = 0; p < 3; p++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        win_reg[p][r][c] <= '0;
                    end
                end
            end
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        cur_col_reg <= col_cnt_reg;
                        cur_row_reg <= row_cnt_reg;
                        if (col_cnt_reg >= cx_p1) begin
                            col_cnt_reg <= '0;
                            row_cnt_reg <= (row_cnt_reg >= cy_p1) ? '0 : row_cnt_reg + CW'(1);
                        end else begin
                            col_cnt_reg <= col_cnt_reg + CW'(1);
                        end
                        state_reg <= F_UPD;
                    end
                end
                F_UPD: begin
                    for (int p = 0; p < 3; p++) begin
                        for (int r = 0; r < 3; r++) begin
                            win_reg[p][r][0] <= win_reg[p][r][1];
                            win_reg[p][r][1] <= win_reg[p][r][2];
                        end
                        win_reg[p][0][2] <= line1_rd_reg[p];
                        win_reg[p][1][2] <= line0_rd_reg[p];
                        win_reg[p][2][2] <= in_trio[p];
                    end
                    state_reg <= interior ? F_PUSH : F_IDLE;
                end
                F_PUSH: begin
                    if (!q_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign push = (state_reg == F_PUSH) && !q_full;

    assign at_w = (cur_col_reg == CW'(2));
    assign at_e = (cur_col_reg == cx_p1);
    assign at_s = (cur_row_reg == CW'(2));
    assign at_n = (cur_row_reg == cy_p1);
    assign row_ok = {cur_row_reg <= cy_eff, 1'b1, cur_row_reg >= CW'(3)};
    assign col_ok = {cur_col_reg <= cx_eff, 1'b1, cur_col_reg >= CW'(3)};

    assign m_w = dws_pkg::side_mode(cfg.phys_side_neumann, cfg.neighbor_present,
                                    cfg.interior_dirichlet, dws_pkg::SideWest);
    assign m_e = dws_pkg::side_mode(cfg.phys_side_neumann, cfg.neighbor_present,
                                    cfg.interior_dirichlet, dws_pkg::SideEast);
    assign m_s = dws_pkg::side_mode(cfg.phys_side_neumann, cfg.neighbor_present,
                                    cfg.interior_dirichlet, dws_pkg::SideSouth);
    assign m_n = dws_pkg::side_mode(cfg.phys_side_neumann, cfg.neighbor_present,
                                    cfg.interior_dirichlet, dws_pkg::SideNorth);

    // Edge ghosts beside an interior cell are replaced; corners keep their loaded value.
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    fix_w[p][r][c] = win_reg[p+1][r][c];
                end
            end
            for (int r = 0; r < 3; r++) begin
                if (row_ok[r] && at_w) begin
                    fix_w[p][r][0] = dws_pkg::apply_mode(m_w, win_reg[p+1][r][0],
                                                         win_reg[p+1][r][1]);
                end
                if (row_ok[r] && at_e) begin
                    fix_w[p][r][2] = dws_pkg::apply_mode(m_e, win_reg[p+1][r][2],
                                                         win_reg[p+1][r][1]);
                end
            end
            for (int c = 0; c < 3; c++) begin
                if (col_ok[c] && at_s) begin
                    fix_w[p][0][c] = dws_pkg::apply_mode(m_s, win_reg[p+1][0][c],
                                                         win_reg[p+1][1][c]);
                end
                if (col_ok[c] && at_n) begin
                    fix_w[p][2][c] = dws_pkg::apply_mode(m_n, win_reg[p+1][2][c],
                                                         win_reg[p+1][1][c]);
                end
            end
        end
    end

    always_comb begin
        push_job.hc   = win_reg[0][1][1];
        push_job.hl   = win_reg[0][1][0];
        push_job.hr   = win_reg[0][1][2];
        push_job.hd   = win_reg[0][0][1];
        push_job.hu   = win_reg[0][2][1];
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                push_job.ex[r][c] = fix_w[0][r][c];
                push_job.ey[r][c] = fix_w[1][r][c];
            end
        end
        push_job.err  = (win_reg[0][1][1] <= 0);
        push_job.last = (cur_col_reg == cx_p1) && (cur_row_reg == cy_p1);
    end

endmodule

`default_nettype wire

// ===== rtl/dws_queue.sv =====
// Two-entry job queue between the stencil front end and the arithmetic
// sequencer. Depends on dws_pkg.
`default_nettype none

module dws_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire dws_pkg::job_t  push_job,
    output logic                full,
    input  wire logic           pop,
    output dws_pkg::job_t       pop_job,
    output logic                empty
);

    localparam int PW = $clog2(dws_pkg::QueueDepth);
    localparam int NW = $clog2(dws_pkg::QueueDepth + 1);

    dws_pkg::job_t  q_mem [dws_pkg::QueueDepth];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]  count_reg;

    assign full    = (count_reg == NW'(dws_pkg::QueueDepth));
    assign empty   = (count_reg == '0);
    assign pop_job = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(dws_pkg::QueueDepth - 1)) ? '0
                                                                          : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(dws_pkg::QueueDepth - 1)) ? '0
                                                                          : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("Job pushed into a full queue.");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("Job popped from an empty queue.");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NW'(dws_pkg::QueueDepth)) else $error("Queue count out of range.");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + NW'(1)))
        else $error("Queue count did not follow a push.");
`endif

endmodule

`default_nettype wire

// ===== rtl/dws_back.sv =====
// Arithmetic sequencer of the stencil: works one queued job through a shared
// rounding, saturating multiplier and holds the result register. Depends on dws_pkg.
`default_nettype none

module dws_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire dws_pkg::cfg_t  cfg,
    input  wire logic           q_empty,
    input  wire dws_pkg::job_t  q_job,
    output logic                pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output dws_pkg::out_t       m_data
);

    localparam int DW = dws_pkg::DataWidth;
    localparam int FB = dws_pkg::FracBits;
    localparam int PWD = 2 * DW;
    localparam logic [5:0] LastStep = 6'd42;
    localparam logic [DW-1:0] Recip3 = 32'hAAAAAAAB;

    typedef enum logic [1:0] {B_IDLE, B_RUN, B_OUT} state_t;

    state_t          state_reg;
    logic [5:0]      step_reg;
    logic            phase_reg;
    logic            m_valid_reg;
    dws_pkg::out_t   m_data_reg;
    dws_pkg::job_t   job_reg;
    logic [PWD-1:0]  prod_reg;
    logic            negr_reg;
    dws_pkg::word_t  t0_reg, p1_reg, p2_reg, p3_reg;
    dws_pkg::word_t  hl3_reg, hr3_reg, hd3_reg, hu3_reg, dxh_reg, dyh_reg;
    dws_pkg::word_t  hc2_reg, a3_reg, ah_reg, dxh3_reg, dyh3_reg;
    dws_pkg::word_t  dxydx_reg, dxydy_reg, dxdx_reg, dydy_reg, fx_reg, fy_reg;

    dws_pkg::word_t  op_a, op_b, res, alpha, idx, idy;
    logic            op_div3;
    logic [DW-1:0]   mag_a, mag_b;
    logic [PWD-FB-1:0] q;
    logic [PWD-FB:0] qv;
    logic [PWD-DW-2:0] q3;
    logic            rem;

    assign alpha = dws_pkg::word_t'({1'b0, cfg.alpha_coef});
    assign idx   = dws_pkg::word_t'({1'b0, cfg.inv_dx});
    assign idy   = dws_pkg::word_t'({1'b0, cfg.inv_dy});

    always_comb begin
        op_a    = '0;
        op_b    = '0;
        op_div3 = 1'b0;
        unique case (step_reg)
            6'd0:  begin op_a = dws_pkg::half_sum(job_reg.hl, job_reg.hc);
                         op_b = op_a; end
            6'd1:  begin op_a = t0_reg; op_b = dws_pkg::half_sum(job_reg.hl, job_reg.hc); end
            6'd2:  begin op_a = dws_pkg::half_sum(job_reg.hr, job_reg.hc);
                         op_b = op_a; end
            6'd3:  begin op_a = t0_reg; op_b = dws_pkg::half_sum(job_reg.hr, job_reg.hc); end
            6'd4:  begin op_a = dws_pkg::half_sum(job_reg.hd, job_reg.hc);
                         op_b = op_a; end
            6'd5:  begin op_a = t0_reg; op_b = dws_pkg::half_sum(job_reg.hd, job_reg.hc); end
            6'd6:  begin op_a = dws_pkg::half_sum(job_reg.hu, job_reg.hc);
                         op_b = op_a; end
            6'd7:  begin op_a = t0_reg; op_b = dws_pkg::half_sum(job_reg.hu, job_reg.hc); end
            6'd8:  begin op_a = dws_pkg::half_diff(job_reg.hr, job_reg.hl); op_b = idx; end
            6'd9:  begin op_a = dws_pkg::half_diff(job_reg.hu, job_reg.hd); op_b = idy; end
            6'd10: begin op_a = job_reg.hc; op_b = job_reg.hc; end
            6'd11: begin op_a = alpha; op_div3 = 1'b1; end
            6'd12: begin op_a = alpha; op_b = job_reg.hc; end
            6'd13: begin op_a = hl3_reg; op_b = job_reg.ex[1][0]; end
            6'd14: begin op_a = dws_pkg::add_s(hl3_reg, hr3_reg); op_b = job_reg.ex[1][1]; end
            6'd15: begin op_a = hr3_reg; op_b = job_reg.ex[1][2]; end
            6'd16: begin op_a = dws_pkg::add_s(dws_pkg::sub_s(p1_reg, p2_reg), p3_reg);
                         op_b = idx; end
            6'd17: begin op_a = t0_reg; op_b = idx; end
            6'd18: begin op_a = hd3_reg; op_b = job_reg.ey[0][1]; end
            6'd19: begin op_a = dws_pkg::add_s(hu3_reg, hd3_reg); op_b = job_reg.ey[1][1]; end
            6'd20: begin op_a = hu3_reg; op_b = job_reg.ey[2][1]; end
            6'd21: begin op_a = dws_pkg::add_s(dws_pkg::sub_s(p1_reg, p2_reg), p3_reg);
                         op_b = idy; end
            6'd22: begin op_a = t0_reg; op_b = idy; end
            6'd23: begin op_a = dws_pkg::sub_s(dws_pkg::sub_s(job_reg.ex[2][2], job_reg.ex[0][2]),
                                               dws_pkg::sub_s(job_reg.ex[2][0], job_reg.ex[0][0]));
                         op_b = idx; end
            6'd24: begin op_a = t0_reg; op_b = idy; end
            6'd25: begin op_a = dws_pkg::sub_s(dws_pkg::sub_s(job_reg.ey[2][2], job_reg.ey[0][2]),
                                               dws_pkg::sub_s(job_reg.ey[2][0], job_reg.ey[0][0]));
                         op_b = idx; end
            6'd26: begin op_a = t0_reg; op_b = idy; end
            6'd27: begin op_a = dws_pkg::half_diff(job_reg.ex[1][2], job_reg.ex[1][0]);
                         op_b = idx; end
            6'd28: begin op_a = dws_pkg::half_diff(job_reg.ey[2][1], job_reg.ey[0][1]);
                         op_b = idy; end
            6'd29: begin op_a = a3_reg; op_b = dxh3_reg; end
            6'd30: begin op_a = job_reg.hc; op_b = job_reg.ex[1][1]; end
            6'd31: begin op_a = job_reg.hc; op_b = dxh_reg; end
            6'd32: begin op_a = t0_reg; op_b = dydy_reg; end
            6'd33: begin op_a = hc2_reg; op_b = dws_pkg::quarter(dxydy_reg); end
            6'd34: begin op_a = t0_reg; op_div3 = 1'b1; end
            6'd35: begin op_a = ah_reg; op_b = dws_pkg::add_s(p3_reg, t0_reg); end
            6'd36: begin op_a = a3_reg; op_b = dyh3_reg; end
            6'd37: begin op_a = job_reg.hc; op_b = job_reg.ey[1][1]; end
            6'd38: begin op_a = job_reg.hc; op_b = dyh_reg; end
            6'd39: begin op_a = t0_reg; op_b = dxdx_reg; end
            6'd40: begin op_a = hc2_reg; op_b = dws_pkg::quarter(dxydx_reg); end
            6'd41: begin op_a = t0_reg; op_div3 = 1'b1; end
            6'd42: begin op_a = ah_reg; op_b = dws_pkg::add_s(p3_reg, t0_reg); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign mag_a = op_a[DW-1] ? DW'(0) - op_a : op_a;
    assign mag_b = op_div3 ? Recip3 : (op_b[DW-1] ? DW'(0) - op_b : op_b);

    // The signed product is rounded toward minus infinity, then saturated.
    assign q   = prod_reg[PWD-1:FB];
    assign rem = |prod_reg[FB-1:0];
    assign qv  = {1'b0, q} + (PWD-FB+1)'(rem);
    assign q3  = prod_reg[PWD-1:DW+1];

    always_comb begin
        if (op_div3) begin
            res = negr_reg ? dws_pkg::word_t'(DW'(0) - {1'b0, q3}) : dws_pkg::word_t'({1'b0, q3});
        end else if (!negr_reg) begin
            res = (|q[PWD-FB-1:DW-1]) ? dws_pkg::WordMax : q[DW-1:0];
        end else begin
            res = (|qv[PWD-FB:DW-1]) ? dws_pkg::WordMin : dws_pkg::word_t'(DW'(0) - qv[DW-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_RUN && !phase_reg) begin
            prod_reg <= PWD'(mag_a) * PWD'(mag_b);
            negr_reg <= op_div3 ? op_a[DW-1] : (op_a[DW-1] ^ op_b[DW-1]);
        end
        if (pop) begin
            job_reg <= q_job;
        end
        if (state_reg == B_RUN && phase_reg) begin
            case (step_reg)
                6'd1:  hl3_reg   <= res;
                6'd3:  hr3_reg   <= res;
                6'd5:  hd3_reg   <= res;
                6'd7:  hu3_reg   <= res;
                6'd8:  dxh_reg   <= res;
                6'd9:  dyh_reg   <= res;
                6'd10: hc2_reg   <= res;
                6'd11: a3_reg    <= res;
                6'd12: ah_reg    <= res;
                6'd13, 6'd18, 6'd29, 6'd36: p1_reg <= res;
                6'd14, 6'd19, 6'd30, 6'd37: p2_reg <= res;
                6'd15, 6'd20, 6'd32, 6'd39: p3_reg <= res;
                6'd17: dxh3_reg  <= res;
                6'd22: dyh3_reg  <= res;
                6'd24: dxydx_reg <= res;
                6'd26: dxydy_reg <= res;
                6'd27: dxdx_reg  <= res;
                6'd28: dydy_reg  <= res;
                6'd35: fx_reg <= dws_pkg::sub_s(dws_pkg::add_s(dws_pkg::neg_s(p1_reg), p2_reg),
                                                res);
                6'd42: fy_reg <= dws_pkg::sub_s(dws_pkg::add_s(dws_pkg::neg_s(p1_reg), p2_reg),
                                                res);
                default: t0_reg <= res;
            endcase
        end
    end

    assign pop = (state_reg == B_IDLE) && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            step_reg    <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        step_reg  <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= q_job.err ? B_OUT : B_RUN;
                    end
                end
                B_RUN: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        if (step_reg == LastStep) begin
                            state_reg <= B_OUT;
                        end else begin
                            step_reg <= step_reg + 6'd1;
                        end
                    end
                end
                B_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.force_x     <= job_reg.err ? '0 : fx_reg;
                        m_data_reg.force_y     <= job_reg.err ? '0 : fy_reg;
                        m_data_reg.depth_error <= job_reg.err;
                        m_data_reg.last_cell   <= job_reg.last;
                        state_reg              <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/dispersive_wave_stencil.sv =====
// Top level of the dispersive wave stencil: configuration registers, front
// end, job queue and arithmetic sequencer. Depends on dws_pkg and the dws_ modules.
`default_nettype none

// The patch streams in raster order with its ghost ring, one request per cell,
// and one result request leaves for each interior cell. The input takes a new
// request only while the front end is idle; a cell passes its idle and update
// states, and an interior cell then waits in the push state until the queue has
// room. The sequencer runs 43 multiply steps, each a multiply and a result phase,
// on a single shared 32 by 32 multiplier, which sets the sustained rate; a two-entry
// queue lets the front end keep filling the line stores while a cell is being worked.
module dispersive_wave_stencil #(
    parameter int MAX_CELLS = dws_pkg::MaxCells
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dws_pkg::in_t       s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dws_pkg::out_t           m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire dws_pkg::cfg_idx_t  cfg_index,
    input  wire logic [31:0]        cfg_data
);

    dws_pkg::cfg_t  cfg_reg;
    dws_pkg::job_t  push_job, pop_job;
    logic           push, pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cells_x            <= 6'd32;
            cfg_reg.cells_y            <= 6'd32;
            cfg_reg.phys_side_neumann  <= '0;
            cfg_reg.neighbor_present   <= '0;
            cfg_reg.interior_dirichlet <= 1'b0;
            cfg_reg.alpha_coef         <= 31'd65536;
            cfg_reg.inv_dx             <= 31'd65536;
            cfg_reg.inv_dy             <= 31'd65536;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dws_pkg::CfgCellsX:   cfg_reg.cells_x            <= cfg_data[5:0];
                dws_pkg::CfgCellsY:   cfg_reg.cells_y            <= cfg_data[5:0];
                dws_pkg::CfgSideNeu:  cfg_reg.phys_side_neumann  <= cfg_data[3:0];
                dws_pkg::CfgNeighbor: cfg_reg.neighbor_present   <= cfg_data[3:0];
                dws_pkg::CfgIntDir:   cfg_reg.interior_dirichlet <= cfg_data[0];
                dws_pkg::CfgAlpha:    cfg_reg.alpha_coef         <= cfg_data[30:0];
                dws_pkg::CfgInvDx:    cfg_reg.inv_dx             <= cfg_data[30:0];
                dws_pkg::CfgInvDy:    cfg_reg.inv_dy             <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    dws_front #(
        .MAX_CELLS (MAX_CELLS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    dws_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    dws_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// ===== verif/dispersive_wave_stencil_tb.sv =====
// Self-checking testbench for dispersive_wave_stencil: streams whole patches with ghost
// rings under random flow control and compares each result with a built-in predictor.
// Depends on dws_pkg and the dispersive_wave_stencil RTL.
module dispersive_wave_stencil_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dws_pkg::*;

    localparam int Line = MaxCells + 2;
    localparam int StallLimit = 4000;
    localparam int DrainCycles = 200;
    localparam int ItemTarget = 1300;
    localparam longint QMax = 64'sd2147483647;
    localparam longint QMin = -64'sd2147483648;
    localparam cfg_idx_t CfgPastEnd = 4'd8;

    typedef longint plane_t [3][3];

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_idx_t cfg_index = CfgCellsX;
    logic [31:0] cfg_data = '0;

    dispersive_wave_stencil dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state.
    logic [5:0] p_cells_x = 6'd32, p_cells_y = 6'd32;
    logic [3:0] p_neumann = '0, p_neighbor = '0;
    logic p_int_dir = 1'b0;
    logic [30:0] p_alpha = 31'd65536, p_inv_dx = 31'd65536, p_inv_dy = 31'd65536;
    longint line_mem [3][2*Line];
    longint win [3][3][3];
    int unsigned col_pos = 0, row_pos = 0;

    in_t cell_queue[$];
    out_t force_queue[$];
    int errors = 0;

    function automatic longint sat_q(input longint v);
        return v > QMax ? QMax : (v < QMin ? QMin : v);
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        longint p;
        p = a * b;
        return sat_q(p >>> FracBits);
    endfunction

    function automatic longint cube_of_mean(input longint a, input longint b);
        longint m;
        m = (a + b) >>> 1;
        return mul_q(mul_q(m, m), m);
    endfunction

    function automatic mode_t ghost_mode(input int side);
        if (!p_neighbor[side]) begin
            return p_neumann[side] ? MODE_COPY : MODE_NEG;
        end
        return p_int_dir ? MODE_NEG : MODE_KEEP;
    endfunction

    function automatic longint ghost_value(input mode_t m, input longint loaded,
                                           input longint src);
        if (m == MODE_COPY) begin
            return src;
        end
        if (m == MODE_NEG) begin
            return sat_q(-src);
        end
        return loaded;
    endfunction

    function automatic void fill_ghosts(output plane_t e, input plane_t w, input int i,
                                        input int j, input int cx, input int cy);
        e = w;
        for (int r = 0; r < 3; r++) begin
            if (j - 1 + r >= 0 && j - 1 + r < cy) begin
                if (i == 0) e[r][0] = ghost_value(ghost_mode(SideWest), w[r][0], w[r][1]);
                if (i == cx - 1) e[r][2] = ghost_value(ghost_mode(SideEast), w[r][2], w[r][1]);
            end
        end
        for (int c = 0; c < 3; c++) begin
            if (i - 1 + c >= 0 && i - 1 + c < cx) begin
                if (j == 0) e[0][c] = ghost_value(ghost_mode(SideSouth), w[0][c], w[1][c]);
                if (j == cy - 1) e[2][c] = ghost_value(ghost_mode(SideNorth), w[2][c], w[1][c]);
            end
        end
    endfunction

    function automatic int eff_size(input logic [5:0] v);
        return v == 0 ? 1 : (v > MaxCells ? MaxCells : int'(v));
    endfunction

    function automatic void predict_cell(input in_t item);
        int cx, cy, col, row;
        longint v [3];
        plane_t h, wx, wy, ex, ey;
        longint hc, fx, fy, alpha, idx, idy, hl3, hr3, hd3, hu3, dxh, dyh, hc2, a3, ah, t;
        longint dxh3, dyh3, dxy_x, dxy_y, dx_x, dy_y;
        out_t res;
        cx = eff_size(p_cells_x);
        cy = eff_size(p_cells_y);
        col = col_pos < Line ? int'(col_pos) : Line - 1;
        row = int'(row_pos);
        v[0] = item.depth;
        v[1] = item.comp_x;
        v[2] = item.comp_y;
        for (int p = 0; p < 3; p++) begin
            for (int r = 0; r < 3; r++) begin
                win[p][r][0] = win[p][r][1];
                win[p][r][1] = win[p][r][2];
            end
            win[p][0][2] = line_mem[p][Line + col];
            win[p][1][2] = line_mem[p][col];
            win[p][2][2] = v[p];
            line_mem[p][Line + col] = line_mem[p][col];
            line_mem[p][col] = v[p];
        end
        if (col >= 2 && row >= 2 && col <= cx + 1 && row <= cy + 1) begin
            h = win[0];
            wx = win[1];
            wy = win[2];
            hc = h[1][1];
            fx = 0;
            fy = 0;
            if (hc > 0) begin
                alpha = p_alpha;
                idx = p_inv_dx;
                idy = p_inv_dy;
                hl3 = cube_of_mean(h[1][0], hc);
                hr3 = cube_of_mean(h[1][2], hc);
                hd3 = cube_of_mean(h[0][1], hc);
                hu3 = cube_of_mean(h[2][1], hc);
                dxh = mul_q((h[1][2] - h[1][0]) >>> 1, idx);
                dyh = mul_q((h[2][1] - h[0][1]) >>> 1, idy);
                hc2 = mul_q(hc, hc);
                a3 = alpha / 3;
                ah = mul_q(alpha, hc);
                fill_ghosts(ex, wx, col - 2, row - 2, cx, cy);
                fill_ghosts(ey, wy, col - 2, row - 2, cx, cy);
                t = sat_q(sat_q(mul_q(hl3, ex[1][0]) - mul_q(sat_q(hl3 + hr3), ex[1][1]))
                          + mul_q(hr3, ex[1][2]));
                dxh3 = mul_q(mul_q(t, idx), idx);
                t = sat_q(sat_q(mul_q(hd3, ey[0][1]) - mul_q(sat_q(hu3 + hd3), ey[1][1]))
                          + mul_q(hu3, ey[2][1]));
                dyh3 = mul_q(mul_q(t, idy), idy);
                t = sat_q(sat_q(ex[2][2] - ex[0][2]) - sat_q(ex[2][0] - ex[0][0]));
                dxy_x = mul_q(mul_q(t, idx), idy) >>> 2;
                t = sat_q(sat_q(ey[2][2] - ey[0][2]) - sat_q(ey[2][0] - ey[0][0]));
                dxy_y = mul_q(mul_q(t, idx), idy) >>> 2;
                dx_x = mul_q((ex[1][2] - ex[1][0]) >>> 1, idx);
                dy_y = mul_q((ey[2][1] - ey[0][1]) >>> 1, idy);
                fx = sat_q(sat_q(sat_q(-mul_q(a3, dxh3)) + mul_q(hc, ex[1][1]))
                     - mul_q(ah, sat_q(mul_q(mul_q(hc, dxh), dy_y) + mul_q(hc2, dxy_y) / 3)));
                fy = sat_q(sat_q(sat_q(-mul_q(a3, dyh3)) + mul_q(hc, ey[1][1]))
                     - mul_q(ah, sat_q(mul_q(mul_q(hc, dyh), dx_x) + mul_q(hc2, dxy_x) / 3)));
            end
            res.force_x = fx[31:0];
            res.force_y = fy[31:0];
            res.depth_error = hc <= 0;
            res.last_cell = col == cx + 1 && row == cy + 1;
            force_queue.push_back(res);
        end
        if (col_pos >= cx + 1) begin
            col_pos = 0;
            row_pos = row_pos >= cy + 1 ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endfunction

    function automatic void apply_reg(input cfg_idx_t idx, input logic [31:0] val);
        case (idx)
            CfgCellsX:   p_cells_x = val[5:0];
            CfgCellsY:   p_cells_y = val[5:0];
            CfgSideNeu:  p_neumann = val[3:0];
            CfgNeighbor: p_neighbor = val[3:0];
            CfgIntDir:   p_int_dir = val[0];
            CfgAlpha:    p_alpha = val[30:0];
            CfgInvDx:    p_inv_dx = val[30:0];
            CfgInvDy:    p_inv_dy = val[30:0];
            default: ;
        endcase
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_cell(s_data);
            if (!s_valid || s_ready) begin
                if (burst_left > 0 && cell_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= cell_queue.pop_front();
                    burst_left--;
                end else begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // Receiver: switches between always ready and random stalls.
    int stall_left = 0, stall_phase = 0;
    bit stalls_on = 1'b0;
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (force_queue.size() == 0) begin
                    report("unexpected result, force_x", m_data.force_x, 0);
                end else begin
                    want = force_queue.pop_front();
                    if (m_data.force_x !== want.force_x)
                        report("force_x", m_data.force_x, want.force_x);
                    if (m_data.force_y !== want.force_y)
                        report("force_y", m_data.force_y, want.force_y);
                    if (m_data.depth_error !== want.depth_error)
                        report("depth_error", m_data.depth_error, want.depth_error);
                    if (m_data.last_cell !== want.last_cell)
                        report("last_cell", m_data.last_cell, want.last_cell);
                end
            end
            if (stall_phase == 0) begin
                stalls_on = $urandom_range(0, 1);
                stall_phase = $urandom_range(200, 3000);
            end else begin
                stall_phase--;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (stalls_on && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 20);
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (cell_queue.size() > 0 || s_valid || force_queue.size() > 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return 63;
            2: return 32;
            3: return $urandom;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic logic [31:0] pick_scale(input bit allow_zero);
        case ($urandom_range(0, 6))
            0: return allow_zero ? 0 : 1;
            1: return 32'h7FFF_FFFF;
            2: return 65536;
            3: return $urandom;
            4: return $urandom_range(1, 1 << 20);
            default: return $urandom_range(1 << 14, 1 << 18);
        endcase
    endfunction

    function automatic logic [31:0] pick_word(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom_range(1 << 15, 1 << 19);
        endcase
    endfunction

    task automatic queue_patch(input int kind, output int count);
        in_t c;
        count = (eff_size(p_cells_x) + 2) * (eff_size(p_cells_y) + 2);
        for (int k = 0; k < count; k++) begin
            c.depth = pick_word(kind == 0 ? 0 : 2);
            if ($urandom_range(0, 24) == 0) c.depth = ($urandom_range(0, 1)) ? 0 : pick_word(1);
            if (kind == 1 && $urandom_range(0, 9) == 0) c.depth = pick_word(0);
            c.comp_x = pick_word(kind == 0 ? 0 : 1);
            c.comp_y = pick_word(kind == 0 ? 0 : 1);
            cell_queue.push_back(c);
        end
    endtask

    initial begin
        int sent, n;
        logic [31:0] sx, sy;
        in_t c;
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 2 * Line; k++) line_mem[p][k] = 0;
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++) win[p][r][k] = 0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed patch: 3 by 3 interior with extreme and nonpositive depths.
        write_reg(CfgCellsX, 3);
        write_reg(CfgCellsY, 3);
        write_reg(CfgSideNeu, 4'b0101);
        write_reg(CfgNeighbor, 4'b0000);
        write_reg(CfgIntDir, 0);
        write_reg(CfgAlpha, 65536);
        write_reg(CfgInvDx, 65536);
        write_reg(CfgInvDy, 2 * 65536);
        write_reg(CfgPastEnd, $urandom);
        for (int k = 0; k < 25; k++) begin
            case (k % 5)
                0: c = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
                1: c = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
                2: c = '{32'sh0001_0000, 32'sh0000_0000, 32'shFFFF_FFFF};
                3: c = '{32'sh0000_0000, 32'sh0002_8000, 32'shFFFE_0000};
                default: c = '{32'sh0003_0000, 32'sh0001_0000, 32'sh0000_8000};
            endcase
            cell_queue.push_back(c);
        end
        wait_idle();

        // Size extremes: oversized and zero sizes with a sweep of boundary modes.
        write_reg(CfgCellsX, 63);
        write_reg(CfgCellsY, 0);
        write_reg(CfgNeighbor, 4'b1111);
        write_reg(CfgIntDir, 1);
        write_reg(CfgAlpha, 32'h7FFF_FFFF);
        write_reg(CfgInvDx, 32'h7FFF_FFFF);
        write_reg(CfgInvDy, 1);
        queue_patch(2, n);
        wait_idle();
        write_reg(CfgCellsX, 0);
        write_reg(CfgCellsY, 40);
        write_reg(CfgSideNeu, 4'b1010);
        write_reg(CfgNeighbor, 4'b0000);
        write_reg(CfgAlpha, 0);
        write_reg(CfgInvDx, 0);
        write_reg(CfgInvDy, 0);
        queue_patch(1, n);
        wait_idle();

        sent = 0;
        while (sent < ItemTarget) begin
            sx = pick_size();
            sy = pick_size();
            if (eff_size(sx[5:0]) > 8) sy = $urandom_range(0, 2);
            else if (eff_size(sy[5:0]) > 8) sx = $urandom_range(0, 2);
            write_reg(CfgCellsX, sx);
            write_reg(CfgCellsY, sy);
            if ($urandom_range(0, 1)) write_reg(CfgSideNeu, $urandom);
            if ($urandom_range(0, 1)) write_reg(CfgNeighbor, $urandom);
            if ($urandom_range(0, 2) == 0) write_reg(CfgIntDir, $urandom);
            if ($urandom_range(0, 1)) write_reg(CfgAlpha, pick_scale(1'b1) | ($urandom & 32'h8000_0000));
            if ($urandom_range(0, 1)) write_reg(CfgInvDx, pick_scale($urandom_range(0, 5) == 0));
            if ($urandom_range(0, 1)) write_reg(CfgInvDy, pick_scale($urandom_range(0, 5) == 0));
            if ($urandom_range(0, 15) == 0) write_reg(cfg_idx_t'($urandom_range(8, 15)), $urandom);
            queue_patch($urandom_range(0, 4) == 0 ? 0 : ($urandom_range(0, 2) == 0 ? 1 : 2), n);
            sent += n;
            wait_idle();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== dispersive_wave_stencil.f =====
rtl/dws_pkg.sv
rtl/dws_front.sv
rtl/dws_queue.sv
rtl/dws_back.sv
rtl/dispersive_wave_stencil.sv
verif/dispersive_wave_stencil_tb.sv
